FILE: hdl/edf_pkg.sv
// Shared types, sizes and codes of the deadline-first day scheduler.
`default_nettype none
package edf_pkg;

	localparam int MAX_TASKS = 128;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int DAY_W     = 16;
	localparam int TIDX_W    = 7;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] ACT_IDLE     = 2'd0;
	localparam logic [1:0] ACT_WORK     = 2'd1;
	localparam logic [1:0] ACT_DEADLINE = 2'd2;
	localparam logic [1:0] ACT_FAILED   = 2'd3;

	// Scan token that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic             go;
		logic             m_found;
		logic             m_nz;
		logic [IDX_W-1:0] m_idx;
		logic             c_found;
		logic [IDX_W-1:0] c_idx;
		logic [DAY_W-1:0] c_dl;
	} edf_token_t;

	// Request broadcast from the controller to every cell.
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [DAY_W-1:0] rel;
		logic [DAY_W-1:0] dl;
		logic [DAY_W-1:0] work;
		logic             dec_en;
		logic [IDX_W-1:0] dec_idx;
		logic [DAY_W-1:0] today;
		logic [CNT_W-1:0] count;
	} edf_bcast_t;

endpackage
`default_nettype wire

FILE: hdl/edf_task_day_scheduler.sv
// Top level of the deadline-first day scheduler: controller and chain of task cells.
// Load, clear and unused requests give no result; busy stays low.
// A tick gives its strobe once the scan token, stepping through the cell chain one cell
// per cycle, has reached its end and the result is registered; a new tick may be
// accepted in the strobe cycle. After the failure flag is set a tick answers next cycle.
// Reset clears the task count, day counter and failure flag; task slots are not cleared.
`default_nettype none
module edf_task_day_scheduler (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 mode,
	input  wire logic [edf_pkg::DAY_W-1:0]  release_day,
	input  wire logic [edf_pkg::DAY_W-1:0]  deadline_day,
	input  wire logic [edf_pkg::DAY_W-1:0]  work_days,
	output logic                            strobe,
	output logic [1:0]                      action,
	output logic [edf_pkg::TIDX_W-1:0]      task_index,
	output logic [edf_pkg::DAY_W-1:0]       day
);
	import edf_pkg::*;

	edf_bcast_t bc;
	edf_token_t tok [MAX_TASKS+1];

	edf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.release_day  (release_day),
		.deadline_day (deadline_day),
		.work_days    (work_days),
		.strobe       (strobe),
		.action       (action),
		.task_index   (task_index),
		.day          (day),
		.bc           (bc),
		.tok_head     (tok[0]),
		.tok_tail     (tok[MAX_TASKS])
	);

	for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
		edf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(k)),
			.bc      (bc),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

endmodule
`default_nettype wire

FILE: hdl/edf_cell.sv
// One task slot of the scheduler chain with its stage of the scan token.
`default_nettype none
module edf_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [edf_pkg::IDX_W-1:0] idx,
	input  wire edf_pkg::edf_bcast_t       bc,
	input  wire edf_pkg::edf_token_t       tok_in,
	output edf_pkg::edf_token_t            tok_out
);
	import edf_pkg::*;

	logic [DAY_W-1:0] rel_q;
	logic [DAY_W-1:0] dl_q;
	logic [DAY_W-1:0] rem_q;
	edf_token_t       nxt;
	logic             live;
	logic             match;
	logic             cand;

	always_ff @(posedge clk) begin
		if (bc.wr_en && bc.wr_idx == idx) begin
			rel_q <= bc.rel;
			dl_q  <= bc.dl;
			rem_q <= bc.work;
		end else if (bc.dec_en && bc.dec_idx == idx) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	assign live  = CNT_W'(idx) < bc.count;
	assign match = live && dl_q == bc.today;
	assign cand  = live && rem_q != '0 && rel_q <= bc.today;

	always_comb begin
		nxt = tok_in;
		// The first deadline match wins, so later cells leave it alone.
		if (!tok_in.m_found && match) begin
			nxt.m_found = 1'b1;
			nxt.m_nz    = rem_q != '0;
			nxt.m_idx   = idx;
		end
		// Strictly earlier deadline only, which keeps the lower index on a tie.
		if (cand && (!tok_in.c_found || dl_q < tok_in.c_dl)) begin
			nxt.c_found = 1'b1;
			nxt.c_idx   = idx;
			nxt.c_dl    = dl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/edf_ctrl.sv
// Request decoder, day counter and result register of the scheduler.
`default_nettype none
module edf_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 mode,
	input  wire logic [edf_pkg::DAY_W-1:0]  release_day,
	input  wire logic [edf_pkg::DAY_W-1:0]  deadline_day,
	input  wire logic [edf_pkg::DAY_W-1:0]  work_days,
	output logic                            strobe,
	output logic [1:0]                      action,
	output logic [edf_pkg::TIDX_W-1:0]      task_index,
	output logic [edf_pkg::DAY_W-1:0]       day,
	output edf_pkg::edf_bcast_t             bc,
	output edf_pkg::edf_token_t             tok_head,
	input  wire edf_pkg::edf_token_t        tok_tail
);
	import edf_pkg::*;

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [DAY_W-1:0] day_q;
	logic             failed_q;
	logic             start_q;
	logic             accept;
	logic             room;
	logic [DAY_W-1:0] day_inc;
	logic             scan_done;

	assign busy      = state_q == S_SCAN;
	assign accept    = start && !busy;
	assign room      = count_q < CNT_W'(MAX_TASKS);
	assign day_inc   = (day_q != '1) ? day_q + 1'b1 : day_q;
	assign scan_done = state_q == S_SCAN && tok_tail.go;

	always_comb begin
		bc.wr_en   = accept && mode == MODE_LOAD && room;
		bc.wr_idx  = count_q[IDX_W-1:0];
		bc.rel     = release_day;
		bc.dl      = deadline_day;
		bc.work    = work_days;
		bc.dec_en  = scan_done && !tok_tail.m_found && tok_tail.c_found;
		bc.dec_idx = tok_tail.c_idx;
		bc.today   = day_q;
		bc.count   = count_q;
	end

	always_comb begin
		tok_head         = '0;
		tok_head.go      = start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			day_q      <= '0;
			failed_q   <= 1'b0;
			start_q    <= 1'b0;
			strobe     <= 1'b0;
			action     <= ACT_IDLE;
			task_index <= '0;
			day        <= '0;
		end else begin
			strobe  <= 1'b0;
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (mode)
							MODE_LOAD: begin
								if (room) count_q <= count_q + 1'b1;
							end
							MODE_TICK: begin
								day_q <= day_inc;
								if (failed_q) begin
									strobe     <= 1'b1;
									action     <= ACT_FAILED;
									task_index <= '0;
									day        <= day_inc;
								end else begin
									start_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							MODE_CLEAR: begin
								count_q  <= '0;
								day_q    <= '0;
								failed_q <= 1'b0;
							end
							MODE_NONE: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (tok_tail.go) begin
						strobe  <= 1'b1;
						day     <= day_q;
						state_q <= S_IDLE;
						if (tok_tail.m_found) begin
							task_index <= TIDX_W'(tok_tail.m_idx);
							if (tok_tail.m_nz) begin
								action   <= ACT_FAILED;
								failed_q <= 1'b1;
							end else begin
								action <= ACT_DEADLINE;
							end
						end else if (tok_tail.c_found) begin
							action     <= ACT_WORK;
							task_index <= TIDX_W'(tok_tail.c_idx);
						end else begin
							action     <= ACT_IDLE;
							task_index <= '0;
						end
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/edf_checker.sv
// Port-level checks of the scheduler and their bind to the top level.
`default_nettype none
module edf_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic [1:0]                mode,
	input wire logic                      strobe,
	input wire logic [1:0]                action,
	input wire logic [edf_pkg::TIDX_W-1:0] task_index,
	input wire logic [edf_pkg::DAY_W-1:0] day
);
	import edf_pkg::*;

	a_tick_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_TICK) |=> (strobe || busy))
		else $error("accepted tick neither answered nor scanning");

	a_no_result_other: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode != MODE_TICK) |=> !strobe)
		else $error("result after a request that gives none");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result shown while busy");

	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> day != '0)
		else $error("result carries day zero");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && action == ACT_IDLE) |-> task_index == '0)
		else $error("idle day with nonzero task index");

endmodule

bind edf_task_day_scheduler edf_checker u_chk (.*);
`default_nettype wire
